### rtl/gdd_pkg.sv
// shared types, constants and month table for the gregorian day difference block
package gdd_pkg;

    localparam int YEAR_W       = 14;
    localparam int MONTH_W      = 4;
    localparam int DAY_W        = 5;
    localparam int COUNT_W      = 22;
    localparam int COUNT_MAX    = 4194303;
    localparam int MAX_YEAR_DEF = 9999;

    localparam int IN_TDATA_W   = 48;
    localparam int OUT_TDATA_W  = 24;

    localparam int STAGES       = 5;

    // floor(y / 100) as (y * 5243) >> 19, exact for y below 43690
    localparam int RECIP_100    = 5243;
    localparam int RECIP_SHIFT  = 19;
    localparam int RECIP_W      = 13;
    localparam int PROD_W       = YEAR_W + RECIP_W;
    localparam int Q100_W       = 8;
    localparam int DIV_100      = 100;
    localparam int DAYS_PER_YR  = 365;

    localparam int MSTART_W     = 9;
    localparam int DOY_W        = 10;
    localparam int LEAPS_W      = 13;
    localparam int Y365_W       = 23;
    localparam int DAYS_W       = 23;

    typedef struct packed {
        logic [YEAR_W-1:0]  year;
        logic [MONTH_W-1:0] month;
        logic [DAY_W-1:0]   day;
    } t_date;

    typedef struct packed {
        logic [STAGES-1:0] adv;
        logic [STAGES-1:0] vld;
    } t_pipe_ctl;

    // days in the months before the given month, month zero and months past twelve clipped
    function automatic logic [MSTART_W-1:0] month_start(input logic [MONTH_W-1:0] m);
        logic [MSTART_W-1:0] v;
        unique case (m)
            4'd0:    v = 9'd0;
            4'd1:    v = 9'd0;
            4'd2:    v = 9'd31;
            4'd3:    v = 9'd59;
            4'd4:    v = 9'd90;
            4'd5:    v = 9'd120;
            4'd6:    v = 9'd151;
            4'd7:    v = 9'd181;
            4'd8:    v = 9'd212;
            4'd9:    v = 9'd243;
            4'd10:   v = 9'd273;
            4'd11:   v = 9'd304;
            4'd12:   v = 9'd334;
            default: v = 9'd365;
        endcase
        return v;
    endfunction

endpackage

### rtl/gdd_pipe_ctl.sv
// valid bits and stall chain of the five stage pipeline
module gdd_pipe_ctl import gdd_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_s_tvalid,
    output logic      o_s_tready,
    input  logic      i_m_tready,
    output t_pipe_ctl o_ctl
);

    logic [STAGES-1:0] r_vld;
    logic [STAGES:0]   ready;
    logic [STAGES-1:0] vin;

    always_comb begin
        ready[STAGES] = i_m_tready;
        for (int k = STAGES - 1; k >= 0; k--) begin
            ready[k] = !r_vld[k] || ready[k+1];
        end
        vin = {r_vld[STAGES-2:0], i_s_tvalid};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            for (int k = 0; k < STAGES; k++) begin
                if (ready[k]) begin
                    r_vld[k] <= vin[k];
                end
            end
        end
    end

    assign o_s_tready = ready[0];
    assign o_ctl.adv  = vin & ready[STAGES-1:0];
    assign o_ctl.vld  = r_vld;

endmodule

### rtl/gdd_date_days.sv
// day number of one date since year zero, over stages one to three
module gdd_date_days import gdd_pkg::*; (
    input  logic              i_clk,
    input  t_pipe_ctl         i_ctl,
    input  t_date             i_date,
    output logic [DAYS_W-1:0] o_days
);

    // stage one
    logic [YEAR_W-1:0]   r_y1;
    logic [DAY_W-1:0]    r_d1;
    logic [MSTART_W-1:0] r_mstart1;
    logic                r_late1;
    logic [Q100_W-1:0]   r_q100;
    logic [PROD_W-1:0]   n_prod;

    // stage two
    logic [Y365_W-1:0]   r_y365;
    logic [LEAPS_W-1:0]  r_leaps;
    logic [DOY_W-1:0]    r_doy;

    logic [YEAR_W-1:0]   n_rem;
    logic [Q100_W:0]     n_c100;
    logic [Q100_W:0]     n_c400;
    logic [YEAR_W:0]     n_y3;
    logic [LEAPS_W-1:0]  n_leaps;
    logic                n_leap;
    logic [DOY_W-1:0]    n_doy;
    logic [Y365_W-1:0]   n_y365;

    // stage three
    logic [DAYS_W-1:0]   r_days;

    assign n_prod = PROD_W'(i_date.year) * PROD_W'(RECIP_100);

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[1]) begin
            r_y1      <= i_date.year;
            r_d1      <= i_date.day;
            r_mstart1 <= month_start(i_date.month);
            r_late1   <= (i_date.month >= MONTH_W'(3));
            r_q100    <= n_prod[RECIP_SHIFT+Q100_W-1:RECIP_SHIFT];
        end
    end

    always_comb begin
        n_rem   = r_y1 - YEAR_W'(YEAR_W'(r_q100) * YEAR_W'(DIV_100));
        n_c100  = {1'b0, r_q100} + (Q100_W+1)'(n_rem != '0);
        n_c400  = (n_c100 + (Q100_W+1)'(3)) >> 2;
        n_y3    = {1'b0, r_y1} + (YEAR_W+1)'(3);
        n_leaps = n_y3[YEAR_W:2] - LEAPS_W'(n_c100) + LEAPS_W'(n_c400);
        n_leap  = (r_y1[1:0] == 2'b00) && ((n_rem != '0) || (r_q100[1:0] == 2'b00));
        n_doy   = DOY_W'(r_mstart1) + DOY_W'(r_late1 && n_leap) + DOY_W'(r_d1);
        n_y365  = Y365_W'(r_y1) * Y365_W'(DAYS_PER_YR);
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[2]) begin
            r_y365  <= n_y365;
            r_leaps <= n_leaps;
            r_doy   <= n_doy;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_ctl.adv[3]) begin
            r_days <= DAYS_W'(r_y365) + DAYS_W'(r_leaps) + DAYS_W'(r_doy);
        end
    end

    assign o_days = r_days;

endmodule

### rtl/gregorian_day_difference.sv
// top level of the gregorian day difference block
// Takes one beat per clock when not held by backpressure and returns one result beat after the five
// register stages: year clamp, reciprocal multiply for the hundreds count with the order
// compare, leap count and 365 multiply, day number sum, and the final difference with
// clamping. Backpressure holds each occupied stage that cannot move on while empty stages
// keep filling, so no beat is lost or repeated and bubbles close up.
// A start date after the end date gives order_error set and a zero count; the count
// saturates at 4194303 and never goes below zero. count_last_day adds one day.
module gregorian_day_difference import gdd_pkg::*; #(
    parameter int MAX_YEAR = MAX_YEAR_DEF
) (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   i_cfg_wr_en,
    input  logic                   i_cfg_wr_data,  // count_last_day
    input  logic                   s_axis_tvalid,
    output logic                   s_axis_tready,
    // start_year, start_month, start_day, end_year, end_month, end_day, zero pad
    input  logic [IN_TDATA_W-1:0]  s_axis_tdata,
    output logic                   m_axis_tvalid,
    input  logic                   m_axis_tready,
    // day_count, zero pad
    output logic [OUT_TDATA_W-1:0] m_axis_tdata,
    // order_error
    output logic                   m_axis_tuser
);

    localparam logic [YEAR_W:0] MAX_YEAR_V = (YEAR_W+1)'(MAX_YEAR);
    localparam logic signed [DAYS_W+1:0] COUNT_MAX_S = (DAYS_W+2)'(COUNT_MAX);

    t_pipe_ctl ctl;
    t_date     in_start;
    t_date     in_end;
    t_date     r_start;
    t_date     r_end;
    logic      r_count_last;
    logic      r_err1;
    logic      r_err2;
    logic      r_err3;
    logic      n_before;
    logic [DAYS_W-1:0] days_start;
    logic [DAYS_W-1:0] days_end;
    logic signed [DAYS_W+1:0] n_diff;
    logic [COUNT_W-1:0] n_count;
    logic [COUNT_W-1:0] r_count;
    logic               r_err;

    function automatic logic [YEAR_W-1:0] clamp_year(input logic [YEAR_W-1:0] y);
        return ({1'b0, y} > MAX_YEAR_V) ? MAX_YEAR_V[YEAR_W-1:0] : y;
    endfunction

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count_last <= 1'b0;
        end else if (i_cfg_wr_en) begin
            r_count_last <= i_cfg_wr_data;
        end
    end

    gdd_pipe_ctl u_ctl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_s_tvalid (s_axis_tvalid),
        .o_s_tready (s_axis_tready),
        .i_m_tready (m_axis_tready),
        .o_ctl      (ctl)
    );

    always_comb begin
        in_start.year  = clamp_year(s_axis_tdata[13:0]);
        in_start.month = s_axis_tdata[17:14];
        in_start.day   = s_axis_tdata[22:18];
        in_end.year    = clamp_year(s_axis_tdata[36:23]);
        in_end.month   = s_axis_tdata[40:37];
        in_end.day     = s_axis_tdata[45:41];
    end

    always_ff @(posedge i_clk) begin
        if (ctl.adv[0]) begin
            r_start <= in_start;
            r_end   <= in_end;
        end
    end

    // year, then month, then day
    always_comb begin
        if (r_end.year != r_start.year) begin
            n_before = r_end.year < r_start.year;
        end else if (r_end.month != r_start.month) begin
            n_before = r_end.month < r_start.month;
        end else begin
            n_before = r_end.day < r_start.day;
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.adv[1]) begin
            r_err1 <= n_before;
        end
        if (ctl.adv[2]) begin
            r_err2 <= r_err1;
        end
        if (ctl.adv[3]) begin
            r_err3 <= r_err2;
        end
    end

    gdd_date_days u_days_start (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_date (r_start),
        .o_days (days_start)
    );

    gdd_date_days u_days_end (
        .i_clk  (i_clk),
        .i_ctl  (ctl),
        .i_date (r_end),
        .o_days (days_end)
    );

    always_comb begin
        n_diff = $signed({2'b00, days_end}) - $signed({2'b00, days_start})
               + $signed({{(DAYS_W+1){1'b0}}, r_count_last});
        if (r_err3 || (n_diff < 0)) begin
            n_count = '0;
        end else if (n_diff > COUNT_MAX_S) begin
            n_count = COUNT_MAX_S[COUNT_W-1:0];
        end else begin
            n_count = n_diff[COUNT_W-1:0];
        end
    end

    always_ff @(posedge i_clk) begin
        if (ctl.adv[4]) begin
            r_count <= n_count;
            r_err   <= r_err3;
        end
    end

    assign m_axis_tvalid = ctl.vld[STAGES-1];
    assign m_axis_tdata  = {{(OUT_TDATA_W-COUNT_W){1'b0}}, r_count};
    assign m_axis_tuser  = r_err;

endmodule

### rtl/gdd_checker.sv
// port level checks on the gregorian day difference block, bound to the top level
module gdd_checker import gdd_pkg::*; (
    input logic                   i_clk,
    input logic                   i_rst_n,
    input logic                   s_axis_tvalid,
    input logic                   s_axis_tready,
    input logic                   m_axis_tvalid,
    input logic                   m_axis_tready,
    input logic [OUT_TDATA_W-1:0] m_axis_tdata,
    input logic                   m_axis_tuser
);

    // nothing valid after a reset cycle
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result beat valid after reset");

    // an order error beat carries a zero count
    a_err_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && m_axis_tuser |-> m_axis_tdata[COUNT_W-1:0] == '0)
        else $error("order error with non-zero count");

    // empty output stage means the pipeline can take a beat
    a_ready_when_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !m_axis_tvalid |-> s_axis_tready)
        else $error("input stalled with empty output");

    // stalled result beat holds
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        m_axis_tvalid && !m_axis_tready |=>
            m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser))
        else $error("stalled result beat changed");

endmodule

bind gregorian_day_difference gdd_checker u_gdd_checker (.*);

### verif/testbench.sv
`timescale 1ns / 100ps
// self-checking testbench for gregorian_day_difference: directed table, then random date pairs
module testbench;
    import gdd_pkg::*;

    localparam int SPAN_BITS      = 2 * (YEAR_W + MONTH_W + DAY_W);
    localparam int N_DIRECTED     = 25;
    localparam int N_PHASES       = 5;
    localparam int PHASE_ITEMS    = 250;
    localparam int HOLD_CYCLES    = 300;
    localparam int TAIL_CYCLES    = 20;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int MAX_REPORTS    = 10;

    typedef struct packed {
        t_date from_date;
        t_date to_date;
    } t_span;

    typedef struct packed {
        logic [COUNT_W-1:0] days;
        logic               order_err;
    } t_span_result;

    typedef struct {
        int sy;
        int sm;
        int sd;
        int ey;
        int em;
        int ed;
        bit typed;
        int days;
        bit err;
    } t_directed_row;

    logic                   i_clk;
    logic                   i_rst_n;
    logic                   i_cfg_wr_en;
    logic                   i_cfg_wr_data;
    logic                   s_axis_tvalid;
    logic                   s_axis_tready;
    logic [IN_TDATA_W-1:0]  s_axis_tdata;
    logic                   m_axis_tvalid;
    logic                   m_axis_tready;
    logic [OUT_TDATA_W-1:0] m_axis_tdata;
    logic                   m_axis_tuser;

    t_span_result pending_spans[$];
    bit           count_last_day_q;
    int           src_idle_pct;
    int           snk_stall_pct;
    bit           hold_req;
    int           spans_sent;
    int           results_checked;
    int           order_errors_seen;
    int           mismatch_count;

    // start y/m/d, end y/m/d, typed, days, order error
    t_directed_row directed_rows[N_DIRECTED] = '{
        '{2000, 1, 1, 2000, 1, 1, 1, 0, 0},
        '{2000, 1, 1, 2000, 1, 2, 1, 1, 0},
        '{2001, 1, 1, 2000, 12, 31, 1, 0, 1},
        '{2000, 5, 1, 2000, 4, 30, 1, 0, 1},
        '{2000, 5, 10, 2000, 5, 9, 1, 0, 1},
        '{0, 0, 0, 0, 0, 0, 1, 0, 0},
        '{0, 1, 1, 1, 1, 1, 1, 366, 0},
        '{1900, 1, 1, 1901, 1, 1, 1, 365, 0},
        '{2000, 1, 1, 2001, 1, 1, 1, 366, 0},
        '{2000, 2, 28, 2000, 3, 1, 1, 2, 0},
        '{1900, 2, 28, 1900, 3, 1, 1, 1, 0},
        '{0, 1, 1, 9999, 12, 31, 0, 0, 0},
        '{16383, 12, 31, 9999, 12, 31, 1, 0, 0},
        '{9999, 1, 1, 12000, 1, 1, 1, 0, 0},
        '{12000, 6, 1, 9999, 5, 1, 1, 0, 1},
        '{2000, 0, 5, 2000, 1, 5, 1, 0, 0},
        '{2001, 13, 0, 2001, 15, 0, 1, 0, 0},
        '{2001, 12, 31, 2001, 13, 0, 1, 0, 0},
        '{2000, 3, 0, 2000, 3, 31, 1, 31, 0},
        '{2000, 13, 31, 2000, 14, 0, 1, 0, 0},
        '{2000, 0, 31, 2000, 1, 0, 1, 0, 0},
        '{16383, 15, 31, 16383, 15, 31, 1, 0, 0},
        '{1, 1, 1, 0, 1, 1, 1, 0, 1},
        '{1970, 1, 1, 2024, 6, 15, 0, 0, 0},
        '{0, 15, 31, 9999, 15, 31, 0, 0, 0}
    };

    gregorian_day_difference dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_wr_en   (i_cfg_wr_en),
        .i_cfg_wr_data (i_cfg_wr_data),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    function automatic int clip_year(logic [YEAR_W-1:0] y);
        return (y > MAX_YEAR_DEF) ? MAX_YEAR_DEF : int'(y);
    endfunction

    function automatic bit is_leap(int y);
        return (y % 400 == 0) || (y % 4 == 0 && y % 100 != 0);
    endfunction

    // days in years 0 up to y-1, year 0 being leap
    function automatic longint whole_year_days(int y);
        longint leaps;
        leaps = (y + 3) / 4 - (y + 99) / 100 + (y + 399) / 400;
        return 365 * longint'(y) + leaps;
    endfunction

    function automatic longint ordinal_in_year(int y, logic [MONTH_W-1:0] m,
                                               logic [DAY_W-1:0] d);
        int     months_before;
        longint sum;
        months_before = (m == 0) ? 0 : ((m - 1 > 12) ? 12 : m - 1);
        case (months_before)
            0:       sum = 0;
            1:       sum = 31;
            2:       sum = 59;
            3:       sum = 90;
            4:       sum = 120;
            5:       sum = 151;
            6:       sum = 181;
            7:       sum = 212;
            8:       sum = 243;
            9:       sum = 273;
            10:      sum = 304;
            11:      sum = 334;
            default: sum = 365;
        endcase
        if (months_before >= 2 && is_leap(y)) begin
            sum = sum + 1;
        end
        return sum + longint'(d);
    endfunction

    // a lies before b, on the fields as given after year saturation
    function automatic bit date_before(t_date a, t_date b);
        int ya;
        int yb;
        ya = clip_year(a.year);
        yb = clip_year(b.year);
        if (ya != yb) begin
            return ya < yb;
        end else if (a.month != b.month) begin
            return a.month < b.month;
        end
        return a.day < b.day;
    endfunction

    function automatic t_span_result predict_span(t_span sp);
        t_span_result r;
        int           sy;
        int           ey;
        longint       total;
        sy = clip_year(sp.from_date.year);
        ey = clip_year(sp.to_date.year);
        r.order_err = date_before(sp.to_date, sp.from_date);
        r.days = '0;
        if (!r.order_err) begin
            total = whole_year_days(ey) + ordinal_in_year(ey, sp.to_date.month, sp.to_date.day)
                  - whole_year_days(sy)
                  - ordinal_in_year(sy, sp.from_date.month, sp.from_date.day)
                  + longint'(count_last_day_q);
            if (total < 0) begin
                total = 0;
            end
            if (total > COUNT_MAX) begin
                total = COUNT_MAX;
            end
            r.days = total[COUNT_W-1:0];
        end
        return r;
    endfunction

    function automatic logic [IN_TDATA_W-1:0] pack_span(t_span sp);
        return {{(IN_TDATA_W-SPAN_BITS){1'b0}},
                sp.to_date.day, sp.to_date.month, sp.to_date.year,
                sp.from_date.day, sp.from_date.month, sp.from_date.year};
    endfunction

    function automatic t_date valid_date();
        t_date d;
        d.year  = YEAR_W'($urandom_range(0, MAX_YEAR_DEF));
        d.month = MONTH_W'($urandom_range(1, 12));
        d.day   = DAY_W'($urandom_range(1, 31));
        return d;
    endfunction

    function automatic t_date edge_year_date();
        t_date d;
        case ($urandom_range(0, 9))
            0:       d.year = 0;
            1:       d.year = 1;
            2:       d.year = 99;
            3:       d.year = 100;
            4:       d.year = 399;
            5:       d.year = 400;
            6:       d.year = 9998;
            7:       d.year = YEAR_W'(MAX_YEAR_DEF);
            8:       d.year = YEAR_W'(MAX_YEAR_DEF + 1);
            default: d.year = {YEAR_W{1'b1}};
        endcase
        d.month = MONTH_W'($urandom_range(0, 15));
        d.day   = DAY_W'($urandom_range(0, 31));
        return d;
    endfunction

    // mostly ordered well-formed pairs, some reversed, some raw and boundary noise
    function automatic t_span random_span();
        t_span sp;
        t_date tmp;
        int    pick;
        pick = $urandom_range(0, 99);
        sp.from_date = valid_date();
        sp.to_date   = valid_date();
        if (pick < 70) begin
            if (pick >= 55) begin
                sp.to_date.year = sp.from_date.year + YEAR_W'($urandom_range(0, 1));
            end
            if (date_before(sp.to_date, sp.from_date)) begin
                tmp = sp.from_date;
                sp.from_date = sp.to_date;
                sp.to_date = tmp;
            end
        end else if (pick < 80) begin
            if (!date_before(sp.to_date, sp.from_date)) begin
                tmp = sp.from_date;
                sp.from_date = sp.to_date;
                sp.to_date = tmp;
            end
        end else if (pick < 90) begin
            sp.from_date.year  = YEAR_W'($urandom_range(0, 16383));
            sp.from_date.month = MONTH_W'($urandom_range(0, 15));
            sp.from_date.day   = DAY_W'($urandom_range(0, 31));
            sp.to_date.year    = YEAR_W'($urandom_range(0, 16383));
            sp.to_date.month   = MONTH_W'($urandom_range(0, 15));
            sp.to_date.day     = DAY_W'($urandom_range(0, 31));
        end else begin
            sp.from_date = edge_year_date();
            sp.to_date   = edge_year_date();
        end
        return sp;
    endfunction

    task automatic offer_span(input t_span sp, input t_span_result want);
        if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            s_axis_tvalid <= 1'b0;
            do @(posedge i_clk); while ($urandom_range(0, 99) < src_idle_pct);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tdata  <= pack_span(sp);
        do @(posedge i_clk); while (!s_axis_tready);
        pending_spans.push_back(want);
        spans_sent++;
    endtask

    task automatic wait_for_results();
        while (pending_spans.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic set_count_last_day(input bit v);
        i_cfg_wr_en   <= 1'b1;
        i_cfg_wr_data <= v;
        @(posedge i_clk);
        i_cfg_wr_en <= 1'b0;
        count_last_day_q = v;
    endtask

    task automatic check_result();
        t_span_result want;
        logic [COUNT_W-1:0] got_days;
        got_days = m_axis_tdata[COUNT_W-1:0];
        results_checked++;
        if (m_axis_tuser) begin
            order_errors_seen++;
        end
        if (pending_spans.size() == 0) begin
            mismatch_count++;
            if (mismatch_count <= MAX_REPORTS) begin
                $display("unexpected result beat: days %0d order_error %0b",
                         got_days, m_axis_tuser);
            end
        end else begin
            want = pending_spans.pop_front();
            if (got_days !== want.days || m_axis_tuser !== want.order_err) begin
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTS) begin
                    $display("result %0d: days expected %0d got %0d, %s %0b got %0b",
                             results_checked, want.days, got_days,
                             "order_error expected", want.order_err, m_axis_tuser);
                end
            end
        end
    endtask

    // result side with random stalls and one long hold-off on request
    initial begin
        m_axis_tready <= 1'b0;
        forever begin
            @(posedge i_clk);
            if (m_axis_tvalid && m_axis_tready) begin
                check_result();
            end
            if (hold_req) begin
                hold_req = 1'b0;
                m_axis_tready <= 1'b0;
                repeat (HOLD_CYCLES) @(posedge i_clk);
            end
            m_axis_tready <= ($urandom_range(0, 99) >= snk_stall_pct);
        end
    end

    // watchdog on cycles without any beat
    initial begin
        int quiet_cycles;
        quiet_cycles = 0;
        forever begin
            @(posedge i_clk);
            if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)) begin
                quiet_cycles = 0;
            end else begin
                quiet_cycles++;
            end
            if (quiet_cycles >= WATCHDOG_LIMIT) begin
                $display("watchdog: no beat for %0d cycles, %0d results outstanding",
                         quiet_cycles, pending_spans.size());
                $display("DONE: errors detected");
                $finish;
            end
        end
    end

    initial begin
        t_span        sp;
        t_span_result want;
        int           row;
        int           phase;
        int           n;
        bit           cfg_val;

        s_axis_tvalid     <= 1'b0;
        s_axis_tdata      <= '0;
        i_cfg_wr_en       <= 1'b0;
        i_cfg_wr_data     <= 1'b0;
        i_rst_n           <= 1'b0;
        count_last_day_q  = 1'b0;
        src_idle_pct      = 0;
        snk_stall_pct     = 0;
        hold_req          = 1'b0;
        spans_sent        = 0;
        results_checked   = 0;
        order_errors_seen = 0;
        mismatch_count    = 0;

        repeat (2) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // directed rows with count_last_day at its reset value
        for (row = 0; row < N_DIRECTED; row++) begin
            sp.from_date.year  = directed_rows[row].sy[YEAR_W-1:0];
            sp.from_date.month = directed_rows[row].sm[MONTH_W-1:0];
            sp.from_date.day   = directed_rows[row].sd[DAY_W-1:0];
            sp.to_date.year    = directed_rows[row].ey[YEAR_W-1:0];
            sp.to_date.month   = directed_rows[row].em[MONTH_W-1:0];
            sp.to_date.day     = directed_rows[row].ed[DAY_W-1:0];
            if (directed_rows[row].typed) begin
                want.days      = directed_rows[row].days[COUNT_W-1:0];
                want.order_err = directed_rows[row].err;
            end else begin
                want = predict_span(sp);
            end
            offer_span(sp, want);
        end
        s_axis_tvalid <= 1'b0;
        wait_for_results();

        for (phase = 0; phase < N_PHASES; phase++) begin
            case (phase)
                0: begin src_idle_pct = 0;  snk_stall_pct = 0;  cfg_val = 1'b1; end
                1: begin src_idle_pct = 80; snk_stall_pct = 0;  cfg_val = 1'b0; end
                2: begin src_idle_pct = 0;  snk_stall_pct = 80; cfg_val = 1'b1; end
                3: begin src_idle_pct = 13; snk_stall_pct = 13; cfg_val = 1'b0; end
                default: begin src_idle_pct = 0; snk_stall_pct = 0; cfg_val = 1'b1; end
            endcase
            set_count_last_day(cfg_val);
            // long result hold-off while beats keep coming, to fill the pipeline
            if (phase == 3) begin
                hold_req = 1'b1;
            end
            for (n = 0; n < PHASE_ITEMS; n++) begin
                sp = random_span();
                offer_span(sp, predict_span(sp));
            end
            s_axis_tvalid <= 1'b0;
            wait_for_results();
        end

        repeat (TAIL_CYCLES) @(posedge i_clk);
        mismatch_count += pending_spans.size();

        $display("%0d date pairs sent (directed table and five idling phases), %s %0d",
                 spans_sent, "results checked", results_checked);
        $display("%0d results with end before start, count_last_day exercised at 0 and 1",
                 order_errors_seen);
        if (mismatch_count == 0) begin
            $display("DONE: 0 errors");
        end else begin
            $display("DONE: errors detected");
        end
        $finish;
    end

endmodule
